// ===== rtl/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants for the sub-region scale unit
// Sizes, field widths, register indexes and the flag bundle passed from the
// position tracker to the datapath.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_WIDTH    = 4096;
  localparam int DATA_W       = 16;

  // Widths of the size registers and bound fields.
  localparam int CH_W = 11;
  localparam int HT_W = 13;
  localparam int WD_W = 13;

  // Position counter widths follow from the maximum sizes.
  localparam int CH_POS_W = $clog2(MAX_CHANNELS);
  localparam int HT_POS_W = $clog2(MAX_HEIGHT);
  localparam int WD_POS_W = $clog2(MAX_WIDTH);

  // Q8.8 arithmetic.
  localparam int SCALE_W = 16;
  localparam int FRAC_W  = 8;
  localparam int SUM_W   = DATA_W + SCALE_W + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_SCALE    = 3'd3,
    REG_MODE     = 3'd4
  } srs_reg_t;

  localparam logic signed [SCALE_W-1:0] UNITY_SCALE = SCALE_W'(1 << FRAC_W);

  typedef struct packed {
    logic in_box;
    logic inst_end;
  } srs_flags_t;

endpackage

// ===== rtl/sub_region_scale_unit.sv =====
// ----------------------------------------------------------------------------
// sub_region_scale_unit: box-region scaler for a streamed tensor
// Top level: configuration registers, the two-stage pipeline and its control.
// ----------------------------------------------------------------------------
// Elements arrive in storage order (column fastest, then row, then channel)
// and the unit tracks their position itself, wrapping at the configured
// sizes. One element is accepted every cycle when the output is not stalled;
// each result is registered in both stages in turn. The first stage tests
// the position against the box carried by the beat, the second stage does the
// single 16x16 multiply, accumulate, rounding and saturation. Configuration
// writes are always taken and must only be issued while the pipeline is empty.
module sub_region_scale_unit
  import srs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [DATA_W-1:0]      in_sample,
  input  logic [DATA_W-1:0]      in_acc_in,
  input  logic [CH_W-1:0]        in_c_first,
  input  logic [CH_W-1:0]        in_c_last,
  input  logic [HT_W-1:0]        in_h_first,
  input  logic [HT_W-1:0]        in_h_last,
  input  logic [WD_W-1:0]        in_w_first,
  input  logic [WD_W-1:0]        in_w_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DATA_W-1:0]      out_result,
  output logic                   out_in_region,
  output logic                   out_instance_end,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CH_W-1:0]           channels_r;
  logic [HT_W-1:0]           height_r;
  logic [WD_W-1:0]           width_r;
  logic signed [SCALE_W-1:0] scale_r;
  logic                      mode_r;

  logic [CH_W-1:0] ch_wr;
  logic [HT_W-1:0] ht_wr;
  logic [WD_W-1:0] wd_wr;

  logic                      s1_valid_r;
  logic signed [DATA_W-1:0]  s1_sample_r;
  logic signed [DATA_W-1:0]  s1_acc_r;
  logic signed [SCALE_W-1:0] s1_factor_r;
  srs_flags_t                s1_flags_r;

  logic                      s2_valid_r;
  logic [DATA_W-1:0]         s2_result_r;
  srs_flags_t                s2_flags_r;

  logic                      adv1, adv2, in_accept;
  srs_flags_t                flags;
  logic signed [DATA_W-1:0]  mac_result;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  // Sizes of zero act as one and oversize values act as the maximum.
  assign ch_wr = (cfg_data[CH_W-1:0] == '0) ? CH_W'(1) :
                 (cfg_data[CH_W-1:0] > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) :
                 cfg_data[CH_W-1:0];
  assign ht_wr = (cfg_data[HT_W-1:0] == '0) ? HT_W'(1) :
                 (cfg_data[HT_W-1:0] > HT_W'(MAX_HEIGHT)) ? HT_W'(MAX_HEIGHT) :
                 cfg_data[HT_W-1:0];
  assign wd_wr = (cfg_data[WD_W-1:0] == '0) ? WD_W'(1) :
                 (cfg_data[WD_W-1:0] > WD_W'(MAX_WIDTH)) ? WD_W'(MAX_WIDTH) :
                 cfg_data[WD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r <= CH_W'(1);
      height_r   <= HT_W'(1);
      width_r    <= WD_W'(1);
      scale_r    <= UNITY_SCALE;
      mode_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHANNELS: channels_r <= ch_wr;
        REG_HEIGHT:   height_r   <= ht_wr;
        REG_WIDTH:    width_r    <= wd_wr;
        REG_SCALE:    scale_r    <= cfg_data[SCALE_W-1:0];
        REG_MODE:     mode_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  assign adv2      = !s2_valid_r || !out_stall;
  assign adv1      = !s1_valid_r || adv2;
  assign in_stall  = !adv1;
  assign in_accept = in_valid && adv1;

  // --------------------------------------------------------------------------
  // Stage 1: position and box test
  // --------------------------------------------------------------------------
  srs_pos u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (in_accept),
    .channels (channels_r),
    .height   (height_r),
    .width    (width_r),
    .c_first  (in_c_first),
    .c_last   (in_c_last),
    .h_first  (in_h_first),
    .h_last   (in_h_last),
    .w_first  (in_w_first),
    .w_last   (in_w_last),
    .flags    (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r <= in_sample;
      s1_acc_r    <= mode_r ? in_acc_in : '0;
      s1_factor_r <= flags.in_box ? scale_r : UNITY_SCALE;
      s1_flags_r  <= flags;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: arithmetic into the output register
  // --------------------------------------------------------------------------
  srs_mac u_mac (
    .sample (s1_sample_r),
    .acc    (s1_acc_r),
    .factor (s1_factor_r),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      s2_result_r <= mac_result;
      s2_flags_r  <= s1_flags_r;
    end
  end

  assign out_valid        = s2_valid_r;
  assign out_result       = s2_result_r;
  assign out_in_region    = s2_flags_r.in_box;
  assign out_instance_end = s2_flags_r.inst_end;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv2) |=> (s1_valid_r && $stable(s1_sample_r) && $stable(s1_flags_r)))
    else $error("first stage lost its beat while held");

endmodule

// ===== rtl/srs_pos.sv =====
// ----------------------------------------------------------------------------
// srs_pos: element position tracker and box test
// Keeps the channel, row and column counters of the current element, tests
// them against the box bounds of the beat and flags the last element.
// ----------------------------------------------------------------------------
module srs_pos
  import srs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic [CH_W-1:0] channels,
  input  logic [HT_W-1:0] height,
  input  logic [WD_W-1:0] width,
  input  logic [CH_W-1:0] c_first,
  input  logic [CH_W-1:0] c_last,
  input  logic [HT_W-1:0] h_first,
  input  logic [HT_W-1:0] h_last,
  input  logic [WD_W-1:0] w_first,
  input  logic [WD_W-1:0] w_last,
  output srs_flags_t      flags
);

  logic [CH_POS_W-1:0] chan_r, chan_nxt;
  logic [HT_POS_W-1:0] row_r, row_nxt;
  logic [WD_POS_W-1:0] col_r, col_nxt;
  logic [CH_W-1:0]     chan_1;
  logic [HT_W-1:0]     row_1;
  logic [WD_W-1:0]     col_1;
  logic                chan_end, row_end, col_end;

  // One-based positions for the bound and size compares.
  assign chan_1 = CH_W'(chan_r) + CH_W'(1);
  assign row_1  = HT_W'(row_r) + HT_W'(1);
  assign col_1  = WD_W'(col_r) + WD_W'(1);

  // A counter left past a shrunken size counts as being at its end.
  assign chan_end = chan_1 >= channels;
  assign row_end  = row_1 >= height;
  assign col_end  = col_1 >= width;

  assign flags.in_box = (chan_1 >= c_first) && (chan_1 <= c_last) &&
                        (row_1 >= h_first) && (row_1 <= h_last) &&
                        (col_1 >= w_first) && (col_1 <= w_last);
  assign flags.inst_end = chan_end && row_end && col_end;

  always_comb begin
    chan_nxt = chan_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (!col_end) begin
      col_nxt = col_1[WD_POS_W-1:0];
    end else begin
      col_nxt = '0;
      if (!row_end) begin
        row_nxt = row_1[HT_POS_W-1:0];
      end else begin
        row_nxt  = '0;
        chan_nxt = chan_end ? '0 : chan_1[CH_POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (advance) begin
      chan_r <= chan_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  // The last element of an instance always returns every counter to zero.
  a_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && flags.inst_end) |=> (chan_r == '0 && row_r == '0 && col_r == '0))
    else $error("instance end did not wrap the position counters");

endmodule

// ===== rtl/srs_mac.sv =====
// ----------------------------------------------------------------------------
// srs_mac: Q8.8 scale, accumulate, round and saturate
// Computes acc*256 + sample*factor, rounds to nearest with ties upward and
// saturates to the signed data range.
// ----------------------------------------------------------------------------
module srs_mac
  import srs_pkg::*;
(
  input  logic signed [DATA_W-1:0]  sample,
  input  logic signed [DATA_W-1:0]  acc,
  input  logic signed [SCALE_W-1:0] factor,
  output logic signed [DATA_W-1:0]  result
);

  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1 << (FRAC_W - 1));

  logic signed [DATA_W+SCALE_W-1:0] prod;
  logic signed [DATA_W+FRAC_W-1:0]  acc_sh;
  logic signed [SUM_W-1:0]          sum;
  logic signed [SUM_W-1:0]          rnd;
  logic [SUM_W-DATA_W:0]            top;
  logic                             ovf;

  assign prod   = sample * factor;
  assign acc_sh = {acc, {FRAC_W{1'b0}}};
  assign sum    = SUM_W'(prod) + SUM_W'(acc_sh) + RND;

  // Arithmetic shift gives the floor, so adding half first rounds ties upward.
  assign rnd = sum >>> FRAC_W;
  assign top = rnd[SUM_W-1:DATA_W-1];
  assign ovf = !((&top) || (~|top));

  assign result = ovf ? {rnd[SUM_W-1], {(DATA_W-1){~rnd[SUM_W-1]}}}
                      : rnd[DATA_W-1:0];

endmodule

// ===== dv/sub_region_scale_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sub_region_scale_unit_tb: self-checking bench for the sub-region scale unit
// Streams tensor elements with box bounds through the unit and compares each
// result beat with a behavioural prediction of position tracking, box test,
// Q8.8 scaling, rounding, saturation and the instance end flag. Directed
// cases come first, then random instances under several idling patterns.
// ----------------------------------------------------------------------------
module sub_region_scale_unit_tb;
  import srs_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] acc_in;
    logic [CH_W-1:0]   c_first;
    logic [CH_W-1:0]   c_last;
    logic [HT_W-1:0]   h_first;
    logic [HT_W-1:0]   h_last;
    logic [WD_W-1:0]   w_first;
    logic [WD_W-1:0]   w_last;
  } element_t;

  typedef struct {
    logic [DATA_W-1:0] result;
    logic              in_region;
    logic              instance_end;
  } scaled_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [DATA_W-1:0]     in_sample;
  logic [DATA_W-1:0]     in_acc_in;
  logic [CH_W-1:0]       in_c_first;
  logic [CH_W-1:0]       in_c_last;
  logic [HT_W-1:0]       in_h_first;
  logic [HT_W-1:0]       in_h_last;
  logic [WD_W-1:0]       in_w_first;
  logic [WD_W-1:0]       in_w_last;
  logic                  out_valid;
  logic                  out_stall;
  logic [DATA_W-1:0]     out_result;
  logic                  out_in_region;
  logic                  out_instance_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predicted configuration and position state.
  int                       num_chans;
  int                       num_rows;
  int                       num_cols;
  logic signed [DATA_W-1:0] scale_q;
  bit                       grad_mode;
  int                       chan_idx;
  int                       row_idx;
  int                       col_idx;

  scaled_t pending_scaled[$];
  int      mismatches;
  int      beats_seen;
  int      tx_idle_pct;
  int      rx_stall_pct;
  int      rx_hold_left;

  sub_region_scale_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_acc_in        (in_acc_in),
    .in_c_first       (in_c_first),
    .in_c_last        (in_c_last),
    .in_h_first       (in_h_first),
    .in_h_last        (in_h_last),
    .in_w_first       (in_w_first),
    .in_w_last        (in_w_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result       (out_result),
    .out_in_region    (out_in_region),
    .out_instance_end (out_instance_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int clamp_size(int raw, int max_size);
    if (raw == 0) return 1;
    if (raw > max_size) return max_size;
    return raw;
  endfunction

  function automatic bit in_span(int pos, int first, int last);
    return (pos + 1 >= first) && (pos + 1 <= last);
  endfunction

  // Works out the result of one accepted element and advances the position.
  function automatic scaled_t predict_scaled(element_t e);
    scaled_t r;
    bit      in_box;
    bit      col_end;
    bit      row_end;
    bit      chan_end;
    longint  acc;
    longint  x;
    longint  q;
    in_box = in_span(chan_idx, int'(e.c_first), int'(e.c_last)) &&
             in_span(row_idx, int'(e.h_first), int'(e.h_last)) &&
             in_span(col_idx, int'(e.w_first), int'(e.w_last));
    acc = grad_mode ? longint'($signed(e.acc_in)) : 0;
    x = acc * 256 + longint'($signed(e.sample)) * (in_box ? longint'(scale_q) : 256);
    q = (x + 128) >>> 8;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    col_end  = col_idx + 1 >= num_cols;
    row_end  = row_idx + 1 >= num_rows;
    chan_end = chan_idx + 1 >= num_chans;
    r.result       = q[DATA_W-1:0];
    r.in_region    = in_box;
    r.instance_end = col_end && row_end && chan_end;
    if (!col_end) begin
      col_idx++;
    end else begin
      col_idx = 0;
      if (!row_end) begin
        row_idx++;
      end else begin
        row_idx = 0;
        chan_idx = chan_end ? 0 : chan_idx + 1;
      end
    end
    return r;
  endfunction

  task automatic write_reg(srs_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_CHANNELS: num_chans = clamp_size(int'(value[CH_W-1:0]), MAX_CHANNELS);
      REG_HEIGHT:   num_rows  = clamp_size(int'(value[HT_W-1:0]), MAX_HEIGHT);
      REG_WIDTH:    num_cols  = clamp_size(int'(value[WD_W-1:0]), MAX_WIDTH);
      REG_SCALE:    scale_q   = value;
      REG_MODE:     grad_mode = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(int chans, int rows, int cols);
    write_reg(REG_CHANNELS, CFG_DATA_W'(chans));
    write_reg(REG_HEIGHT, CFG_DATA_W'(rows));
    write_reg(REG_WIDTH, CFG_DATA_W'(cols));
  endtask

  // Idle gap before the next beat, drawn cycle by cycle.
  function automatic int idle_gap();
    int n;
    n = 0;
    while (n < 20 && $urandom_range(99) < tx_idle_pct) n++;
    return n;
  endfunction

  task automatic send_element(element_t e);
    int gap;
    @(negedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_sample  <= e.sample;
    in_acc_in  <= e.acc_in;
    in_c_first <= e.c_first;
    in_c_last  <= e.c_last;
    in_h_first <= e.h_first;
    in_h_last  <= e.h_last;
    in_w_first <= e.w_first;
    in_w_last  <= e.w_last;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_scaled.push_back(predict_scaled(e));
  endtask

  function automatic element_t make_element(int s, int a, int cf, int cl, int hf, int hl,
                                            int wf, int wl);
    element_t e;
    e.sample  = DATA_W'(s);
    e.acc_in  = DATA_W'(a);
    e.c_first = CH_W'(cf);
    e.c_last  = CH_W'(cl);
    e.h_first = HT_W'(hf);
    e.h_last  = HT_W'(hl);
    e.w_first = WD_W'(wf);
    e.w_last  = WD_W'(wl);
    return e;
  endfunction

  // Drops valid, then waits until every outstanding result has arrived.
  task automatic wait_until_drained();
    int guard;
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (pending_scaled.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_scaled.size() != 0) begin
      $display("%0d expected results never arrived", pending_scaled.size());
      mismatches += pending_scaled.size();
      pending_scaled.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // Result checker: one beat per rising edge at most.
  always @(posedge clk) begin
    scaled_t got;
    scaled_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.result       = out_result;
      got.in_region    = out_in_region;
      got.instance_end = out_instance_end;
      if (pending_scaled.size() == 0) begin
        if (mismatches < 10)
          $display("beat %0d: unexpected result %h region %b end %b", beats_seen,
                   got.result, got.in_region, got.instance_end);
        mismatches++;
      end else begin
        want = pending_scaled.pop_front();
        if (got.result !== want.result || got.in_region !== want.in_region ||
            got.instance_end !== want.instance_end) begin
          if (mismatches < 10)
            $display("beat %0d: expected %h/%b/%b, got %h/%b/%b", beats_seen,
                     want.result, want.in_region, want.instance_end,
                     got.result, got.in_region, got.instance_end);
          mismatches++;
        end
      end
      beats_seen++;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic test_defaults();
    send_element(make_element(16'h7FFF, 0, 1, 1, 1, 1, 1, 1));
    send_element(make_element(16'h8000, 16'h1234, 1, 1, 1, 1, 1, 1));
    send_element(make_element(16'h0001, 0, 1, 0, 1, 0, 1, 0));
    send_element(make_element(16'hFFFF, 0, 0, 1, 0, 1, 0, 1));
    wait_until_drained();
  endtask

  // Saturation at the largest scale and the odd shapes of box bounds.
  task automatic test_saturation_and_bounds();
    set_sizes(2, 2, 2);
    write_reg(REG_SCALE, 16'h7FFF);
    write_reg(REG_MODE, 16'd0);
    send_element(make_element(16'h7FFF, 0, 1, 2, 1, 2, 1, 2));
    send_element(make_element(16'h8000, 0, 1, 2, 1, 2, 1, 2));
    send_element(make_element(256, 0, 0, 2, 0, 2, 0, 2));
    send_element(make_element(100, 0, 1, 1, 2, 2, 2, 2));
    send_element(make_element(100, 0, 1, 0, 1, 2, 1, 2));
    send_element(make_element(-5, 0, 2, 1, 1, 2, 1, 2));
    send_element(make_element(1, 0, 2, 2, 1, 1, 2, 2));
    send_element(make_element(-1, 0, 0, 2047, 0, 8191, 0, 8191));
    wait_until_drained();
  endtask

  // Accumulate mode, ties in rounding, clamped size writes.
  task automatic test_gradient_rounding();
    write_reg(REG_CHANNELS, 16'd0);
    write_reg(REG_HEIGHT, 16'hFFFF);
    write_reg(REG_WIDTH, 16'hFFFF);
    write_reg(REG_SCALE, 16'd128);
    write_reg(REG_MODE, 16'd1);
    send_element(make_element(1, 0, 1, 1, 1, 1, 1, 8191));
    send_element(make_element(-1, 0, 1, 1, 1, 1, 1, 8191));
    send_element(make_element(3, 0, 1, 1, 1, 1, 1, 8191));
    send_element(make_element(-3, 0, 1, 1, 1, 1, 1, 8191));
    send_element(make_element(16'h7FFF, 16'h7FFF, 1, 1, 1, 1, 1, 0));
    send_element(make_element(16'h8000, 16'h8000, 1, 1, 1, 1, 1, 0));
    wait_until_drained();
    write_reg(REG_SCALE, 16'h8000);
    send_element(make_element(16'h8000, 0, 1, 1, 1, 1, 1, 8191));
    send_element(make_element(1, 100, 1, 1, 1, 1, 1, 8191));
    wait_until_drained();
  endtask

  // The counters keep running when the sizes shrink under them.
  task automatic test_resize_mid_instance();
    write_reg(REG_MODE, 16'd0);
    write_reg(REG_SCALE, 16'h0100);
    set_sizes(1, 1, 4);
    repeat (3) send_element(make_element($urandom, 16'h7FFF, 1, 1, 1, 1, 2, 3));
    wait_until_drained();
    write_reg(REG_WIDTH, 16'd2);
    repeat (3) send_element(make_element($urandom, $urandom, 1, 1, 1, 1, 1, 1));
    wait_until_drained();
  endtask

  function automatic int pick_value();
    case ($urandom_range(15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 0;
      3: return 16'hFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_bounds(int size, output int first, output int last);
    int r;
    r = $urandom_range(99);
    if (r < 72) begin
      first = $urandom_range(1, size);
      last  = $urandom_range(first, size);
    end else if (r < 84) begin
      first = $urandom_range(1);
      last  = size + $urandom_range(1);
    end else if (r < 92) begin
      first = $urandom_range(1, size + 1);
      last  = $urandom_range(1) ? 0 : first - 1;
    end else begin
      first = $urandom;
      last  = $urandom;
    end
  endtask

  task automatic configure_random();
    if ($urandom_range(6) == 0) begin
      set_sizes($urandom_range(1, 2), $urandom_range(0, 2), $urandom_range(40, 300));
    end else begin
      set_sizes($urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 6));
    end
    write_reg(REG_SCALE,
              CFG_DATA_W'(($urandom_range(3) == 0) ? pick_value() : $urandom));
    write_reg(REG_MODE, CFG_DATA_W'($urandom_range(1)));
  endtask

  // Random instances: one box per instance, with some noise beats mixed in.
  task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct, bit long_hold);
    int sent;
    int run;
    int cf, cl, hf, hl, wf, wl;
    element_t e;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int half = 0; half < 2; half++) begin
      configure_random();
      sent = 0;
      while (sent < n_items / 2) begin
        pick_bounds(num_chans, cf, cl);
        pick_bounds(num_rows, hf, hl);
        pick_bounds(num_cols, wf, wl);
        run = num_chans * num_rows * num_cols;
        for (int i = 0; i < run && sent < n_items / 2; i++) begin
          e = make_element(pick_value(), pick_value(), cf, cl, hf, hl, wf, wl);
          if ($urandom_range(19) == 0)
            e = make_element($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
          if (long_hold && half == 0 && sent == 30)
            rx_hold_left = 80;
          send_element(e);
          sent++;
        end
      end
      wait_until_drained();
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    in_acc_in    = '0;
    in_c_first   = '0;
    in_c_last    = '0;
    in_h_first   = '0;
    in_h_last    = '0;
    in_w_first   = '0;
    in_w_last    = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_CHANNELS;
    cfg_data     = '0;
    mismatches   = 0;
    beats_seen   = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = 0;
    num_chans    = 1;
    num_rows     = 1;
    num_cols     = 1;
    scale_q      = UNITY_SCALE;
    grad_mode    = 1'b0;
    chan_idx     = 0;
    row_idx      = 0;
    col_idx      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_saturation_and_bounds();
    test_gradient_rounding();
    test_resize_mid_instance();
    test_random_traffic(276, 0, 0, 1'b1);
    test_random_traffic(276, 59, 0, 1'b0);
    test_random_traffic(276, 0, 59, 1'b0);
    test_random_traffic(276, 29, 29, 1'b0);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule
